// ===== hdl/dsst_pkg.sv =====
// Shared types and constants for the delayed signal slot table.
// Imported by dsst_alu, delayed_signal_slot_table_unit and the bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dsst_pkg;

   localparam int SLOT_COUNT   = 16;
   localparam int SIGNAL_TOTAL = 8;

   localparam int OP_W       = 2;
   localparam int SIG_FIELD_W = 4;
   localparam int TICK_W     = 32;
   localparam int KIND_W     = 2;
   localparam int MASK_W     = 8;
   localparam int MASK_IDX_W = $clog2(MASK_W);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SIG_W  = (SIGNAL_TOTAL > 1) ? $clog2(SIGNAL_TOTAL) : 1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 2'd0,
      OP_SCHEDULE = 2'd1,
      OP_DISPATCH = 2'd2,
      OP_RAISE    = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPLY   = 2'd0,
      KIND_DELIVER = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CHECK,
      ST_END
   } state_type;

   typedef struct packed {
      logic subtract;
   } alu_ctrl_type;

   typedef struct packed {
      logic [SIG_W-1:0]  sig;
      logic [TICK_W-1:0] due;
   } slot_entry_type;

endpackage

`default_nettype wire

// ===== hdl/dsst_alu.sv =====
// Shared 32-bit add/subtract unit: due tick sums, tick increment, due compare.
// Depends on dsst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsst_alu (
   input  wire dsst_pkg::alu_ctrl_type       ctrl,
   input  wire logic [dsst_pkg::TICK_W-1:0]  operand_a,
   input  wire logic [dsst_pkg::TICK_W-1:0]  operand_b,
   output logic      [dsst_pkg::TICK_W-1:0]  sum,
   output logic                              carry
);
   import dsst_pkg::*;

   logic [TICK_W-1:0] b_eff;

   // subtract: carry out set means a >= b (unsigned)
   assign b_eff = ctrl.subtract ? ~operand_b : operand_b;
   assign {carry, sum} = {1'b0, operand_a} + {1'b0, b_eff} + (TICK_W + 1)'(ctrl.subtract);

endmodule

`default_nettype wire

// ===== hdl/delayed_signal_slot_table_unit.sv =====
// Delayed signal slot table: request/response channels, one CSR word.
// Usage:
//   req_*  : one word per operation (tick, schedule, dispatch, raise).
//   rsp_*  : result words; rsp_last marks the final word of an operation.
//   csr_*  : handler enable mask write, always ready; write only while idle.
// Operation flow, from the accepting edge:
//   tick      : no result; passes through the exec state, then ready again.
//   schedule,
//   raise     : one registered reply word; ready again as it is emitted.
//   dispatch  : the shared ALU compares one slot per read/check state pair
//               (slot RAM read, then compare) and waits in check while a
//               hit word is stalled; the end marker word turns valid and
//               req_ready returns in the same cycle.
// The block takes one operation at a time; req_ready is low until done.
// A stalled rsp_ready holds the result register and halts the sequencer
// at the next word it needs to emit; nothing is dropped.
// Reset clears the tick counter, all slot used bits and the mask; slot
// RAM contents are left alone and only matter for used slots.
// Depends on dsst_pkg and dsst_alu.
`timescale 1ns / 1ps
`default_nettype none

module delayed_signal_slot_table_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [dsst_pkg::OP_W-1:0]           req_operation,
   input  wire logic [dsst_pkg::SIG_FIELD_W-1:0]    req_signal_number,
   input  wire logic [dsst_pkg::TICK_W-1:0]         req_delay,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [dsst_pkg::KIND_W-1:0]         rsp_result_kind,
   output logic      [dsst_pkg::SIG_FIELD_W-1:0]    rsp_signal_out,
   output logic                                     rsp_ok,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dsst_pkg::MASK_W-1:0]         csr_handler_enable_mask
);
   import dsst_pkg::*;

   function automatic logic handler_on(input logic [SIG_FIELD_W-1:0] s,
                                       input logic [MASK_W-1:0]      m);
      return (int'(s) < SIGNAL_TOTAL) && (int'(s) < MASK_W) && m[s[MASK_IDX_W-1:0]];
   endfunction

   state_type                state_ff, state_in;
   op_type                   op_ff;
   logic [SIG_FIELD_W-1:0]   sig_ff;
   logic [TICK_W-1:0]        delay_ff;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [SLOT_COUNT-1:0]    used_ff, used_in;
   logic [SLOT_W-1:0]        idx_ff, idx_in;
   logic [MASK_W-1:0]        mask_ff;
   slot_entry_type           slot_mem [SLOT_COUNT];
   slot_entry_type           rd_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   kind_type                 rsp_kind_ff;
   logic [SIG_FIELD_W-1:0]   rsp_sig_ff;
   logic                     rsp_ok_ff, rsp_last_ff;

   // sequencer controls
   logic                     accept, out_free;
   logic                     emit, emit_ok, emit_last;
   kind_type                 emit_kind;
   logic [SIG_FIELD_W-1:0]   emit_sig;
   logic                     mem_we, rd_en, tick_we, used_set, used_clr;
   logic                     free_found, sig_valid, hit, last_slot;
   logic [SLOT_W-1:0]        free_idx;
   logic [SIG_FIELD_W-1:0]   rd_sig_ext;

   alu_ctrl_type             alu_ctrl;
   logic [TICK_W-1:0]        alu_b, alu_sum;
   logic                     alu_carry;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sig_valid = int'(sig_ff) < SIGNAL_TOTAL;
   assign rd_sig_ext = SIG_FIELD_W'(rd_ff.sig);
   assign last_slot = (idx_ff == SLOT_W'(SLOT_COUNT - 1));

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // shared ALU operand select
   always_comb begin
      alu_ctrl.subtract = (state_ff == ST_CHECK);
      case (state_ff)
         ST_CHECK: alu_b = rd_ff.due;
         default:  alu_b = (op_ff == OP_TICK) ? TICK_W'(1) : delay_ff;
      endcase
   end

   dsst_alu u_alu (
      .ctrl      (alu_ctrl),
      .operand_a (tick_ff),
      .operand_b (alu_b),
      .sum       (alu_sum),
      .carry     (alu_carry)
   );

   assign hit = used_ff[idx_ff] && alu_carry;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (op_type'(req_operation) == OP_DISPATCH) ? ST_READ : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_TICK || out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_CHECK;
         ST_CHECK: begin
            if (!hit || out_free) begin
               state_in = last_slot ? ST_END : ST_READ;
            end
         end
         ST_END: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      emit      = 1'b0;
      emit_kind = KIND_REPLY;
      emit_sig  = sig_ff;
      emit_ok   = 1'b0;
      emit_last = 1'b1;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      tick_we   = 1'b0;
      used_set  = 1'b0;
      used_clr  = 1'b0;
      idx_in    = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_TICK: tick_we = 1'b1;
               OP_SCHEDULE: begin
                  emit    = out_free;
                  emit_ok = sig_valid && free_found;
                  mem_we  = emit && emit_ok;
                  used_set = mem_we;
               end
               default: begin
                  emit    = out_free;
                  emit_ok = handler_on(sig_ff, mask_ff);
               end
            endcase
         end
         ST_READ: rd_en = 1'b1;
         ST_CHECK: begin
            emit_kind = KIND_DELIVER;
            emit_sig  = rd_sig_ext;
            emit_ok   = handler_on(rd_sig_ext, mask_ff);
            emit_last = 1'b0;
            if (hit && out_free) begin
               emit     = 1'b1;
               used_clr = 1'b1;
            end
            if ((!hit || out_free) && !last_slot) begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_END: begin
            emit_kind = KIND_END;
            emit_sig  = '0;
            emit      = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      used_in = used_ff;
      if (used_set) begin
         used_in[free_idx] = 1'b1;
      end
      if (used_clr) begin
         used_in[idx_ff] = 1'b0;
      end
      tick_in      = tick_we ? alu_sum : tick_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         used_ff      <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         used_ff      <= used_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_handler_enable_mask;
         end
      end
   end

   // hold request word and result word
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_operation);
         sig_ff   <= req_signal_number;
         delay_ff <= req_delay;
      end
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_sig_ff  <= emit_sig;
         rsp_ok_ff   <= emit_ok;
         rsp_last_ff <= emit_last;
      end
   end

   // slot RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[free_idx] <= '{sig: sig_ff[SIG_W-1:0], due: alu_sum};
      end
      if (rd_en) begin
         rd_ff <= slot_mem[idx_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_signal_out  = rsp_sig_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_TICK) |=> ##1 (tick_ff == $past(tick_ff, 2) + TICK_W'(1)))
      else $error("tick word did not advance the counter");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_END) |-> (rsp_last && !rsp_ok && rsp_signal_out == '0))
      else $error("malformed end marker");

   a_deliver_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_DELIVER) |-> (!rsp_last && int'(rsp_signal_out) < SIGNAL_TOTAL))
      else $error("delivered word out of range or marked last");

   a_schedule_takes_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && op_ff == OP_SCHEDULE && emit && emit_ok)
      |=> ($countones(used_ff) == $countones($past(used_ff)) + 1))
      else $error("successful schedule did not take exactly one slot");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_delayed_signal_slot_table_unit.sv =====
// Self-checking bench for delayed_signal_slot_table_unit: directed and random
// tick, schedule, dispatch and raise words against a mirror of the slot table.
// Depends on dsst_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_delayed_signal_slot_table_unit;
   import dsst_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD   = 400;

   // Mirror of the slot table; holds the result words each request should yield.
   class pending_signal_table;
      typedef struct {
         kind_type         kind;
         logic [3:0]       sig;
         logic             ok;
         logic             last;
      } result_word;

      result_word   result_words[$];
      logic [31:0]  now_tick;
      bit           slot_busy[SLOT_COUNT];
      logic [3:0]   slot_sig[SLOT_COUNT];
      logic [31:0]  slot_due_at[SLOT_COUNT];
      logic [7:0]   enable_mask;
      int           errors;

      function new();
         now_tick = 0;
         enable_mask = 0;
         errors = 0;
         foreach (slot_busy[i]) slot_busy[i] = 0;
      endfunction

      function void set_mask(logic [7:0] mask);
         enable_mask = mask;
      endfunction

      function int pending();
         return result_words.size();
      endfunction

      function logic handler_enabled(logic [3:0] sig);
         if (sig >= SIGNAL_TOTAL || sig >= 8) return 1'b0;
         return enable_mask[sig[2:0]];
      endfunction

      function void add_word(kind_type kind, logic [3:0] sig, logic ok, logic last);
         result_word w;
         w.kind = kind;
         w.sig  = sig;
         w.ok   = ok;
         w.last = last;
         result_words.push_back(w);
      endfunction

      function void note_request(op_type op, logic [3:0] sig, logic [31:0] delay);
         bit taken;
         taken = 0;
         case (op)
            OP_TICK: begin
               now_tick = now_tick + 1;
            end
            OP_SCHEDULE: begin
               if (sig < SIGNAL_TOTAL) begin
                  for (int i = 0; i < SLOT_COUNT && !taken; i++) begin
                     if (!slot_busy[i]) begin
                        slot_busy[i]   = 1;
                        slot_sig[i]    = sig;
                        slot_due_at[i] = now_tick + delay;
                        taken = 1;
                     end
                  end
               end
               add_word(KIND_REPLY, sig, taken, 1'b1);
            end
            OP_DISPATCH: begin
               // plain unsigned compare, so a wrapped due tick goes out at once
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (slot_busy[i] && now_tick >= slot_due_at[i]) begin
                     slot_busy[i] = 0;
                     add_word(KIND_DELIVER, slot_sig[i], handler_enabled(slot_sig[i]), 1'b0);
                  end
               end
               add_word(KIND_END, 4'd0, 1'b0, 1'b1);
            end
            default: begin
               add_word(KIND_REPLY, sig, handler_enabled(sig), 1'b1);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: rsp_%s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [1:0] kind, logic [3:0] sig, logic ok, logic last);
         result_word w;
         if (result_words.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual kind %0h sig %0h ok %0b last %0b",
                     $time, kind, sig, ok, last);
            errors++;
            return;
         end
         w = result_words.pop_front();
         compare_field("result_kind", w.kind, kind);
         compare_field("signal_out", w.sig, sig);
         compare_field("ok", w.ok, ok);
         compare_field("last", w.last, last);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_operation = OP_TICK;
   logic [SIG_FIELD_W-1:0] req_signal_number = '0;
   logic [TICK_W-1:0]      req_delay = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [KIND_W-1:0]      rsp_result_kind;
   logic [SIG_FIELD_W-1:0] rsp_signal_out;
   logic                   rsp_ok;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [MASK_W-1:0]      csr_handler_enable_mask = '0;

   pending_signal_table table_mirror;
   int accepted_items = 0;
   int burst_left = 1;
   int stall_cycles = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int rsp_cycle = 0;

   always #5 clock = ~clock;

   delayed_signal_slot_table_unit u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_operation           (req_operation),
      .req_signal_number       (req_signal_number),
      .req_delay               (req_delay),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_result_kind         (rsp_result_kind),
      .rsp_signal_out          (rsp_signal_out),
      .rsp_ok                  (rsp_ok),
      .rsp_last                (rsp_last),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_handler_enable_mask (csr_handler_enable_mask)
   );

   // Result side: check accepted words, then pick the next ready level.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_ready)
         table_mirror.check_response(rsp_result_kind, rsp_signal_out, rsp_ok, rsp_last);
      rsp_cycle++;
      if (!hold_done && accepted_items >= 150) begin
         hold_done = 1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         // hold off long enough for the request side to back up
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ((rsp_cycle / 256) % 3)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ((rsp_cycle % 5) < 2);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic push_request(op_type op, logic [3:0] sig, logic [31:0] delay);
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_signal_number <= sig;
      req_delay         <= delay;
      do @(posedge clock); while (req_ready !== 1'b1);
      table_mirror.note_request(op, sig, delay);
      accepted_items++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   // Drop valid and wait until every word is back; ticks give no word, so pad.
   task automatic drain_table();
      req_valid <= 1'b0;
      while (table_mirror.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mask(logic [7:0] mask);
      drain_table();
      csr_valid               <= 1'b1;
      csr_handler_enable_mask <= mask;
      do @(posedge clock); while (csr_ready !== 1'b1);
      table_mirror.set_mask(mask);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(0, 12);
      // near the top so that due wraps past zero
      if (r < 95) return 32'hFFFF_FFFF - $urandom_range(0, 3);
      return $urandom;
   endfunction

   task automatic push_random_item();
      logic [3:0] sig;
      int         r;
      op_type     op;
      r   = $urandom_range(0, 99);
      sig = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 15));
      if (r < 30)      op = OP_TICK;
      else if (r < 62) op = OP_SCHEDULE;
      else if (r < 77) op = OP_DISPATCH;
      else             op = OP_RAISE;
      push_request(op, sig, (op == OP_SCHEDULE) ? pick_delay() : 32'($urandom));
   endtask

   // Overfill the table, let it come due, then sweep it.
   task automatic fill_table();
      repeat (SLOT_COUNT + 1)
         push_request(OP_SCHEDULE, 4'($urandom_range(0, 7)), $urandom_range(0, 3));
      repeat (4) push_request(OP_TICK, 4'($urandom_range(0, 15)), $urandom);
      push_request(OP_DISPATCH, 4'($urandom_range(0, 15)), $urandom);
   endtask

   task automatic run_random_phase(int count);
      int target;
      target = accepted_items + count;
      while (accepted_items < target) begin
         if ($urandom_range(0, 9) == 0) fill_table();
         else push_random_item();
      end
   endtask

   initial begin
      table_mirror = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_mask(8'hA5);
      push_request(OP_RAISE, 4'd0, 32'd0);
      push_request(OP_RAISE, 4'd1, 32'd0);
      push_request(OP_RAISE, 4'd7, 32'd0);
      push_request(OP_RAISE, 4'd8, 32'd0);
      push_request(OP_RAISE, 4'd15, 32'hFFFF_FFFF);
      push_request(OP_DISPATCH, 4'd15, 32'hFFFF_FFFF);
      push_request(OP_TICK, 4'd15, 32'hFFFF_FFFF);
      push_request(OP_TICK, 4'd0, 32'd0);
      push_request(OP_TICK, 4'd9, 32'h5A5A_5A5A);
      push_request(OP_SCHEDULE, 4'd0, 32'd0);
      push_request(OP_SCHEDULE, 4'd7, 32'hFFFF_FFFF);
      push_request(OP_SCHEDULE, 4'd8, 32'd0);
      push_request(OP_SCHEDULE, 4'd15, 32'd1);
      push_request(OP_SCHEDULE, 4'd5, 32'd2);
      push_request(OP_SCHEDULE, 4'd1, 32'd1);
      push_request(OP_DISPATCH, 4'd0, 32'd0);
      push_request(OP_TICK, 4'd0, 32'd0);
      push_request(OP_TICK, 4'd0, 32'd0);
      push_request(OP_DISPATCH, 4'd3, 32'd7);
      push_request(OP_RAISE, 4'd5, 32'd0);

      write_mask(8'hFF);
      run_random_phase(75);
      write_mask(8'h00);
      run_random_phase(75);
      write_mask(8'h5A);
      run_random_phase(75);
      write_mask(8'($urandom));
      run_random_phase(75);

      drain_table();
      repeat (50) @(posedge clock);
      if (table_mirror.errors == 0 && table_mirror.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
